// File: rtl/pmc_pkg.sv
package pmc_pkg;

  // field widths
  localparam int ANGLE_W = 13;
  localparam int TURN_W  = 15;
  localparam int POS_W   = 29;
  localparam int STAMP_W = 32;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 15;
  localparam int CUR_W   = 16;
  localparam int VEL_W   = 31;
  localparam int ERR_W   = 14;

  localparam int HALF_TURN = 4096;

  // velocity scale: 1920000000 / counts per turn
  localparam int VEL_SCALE = 234375;

  // serial multiplier: MUL_A_W x MUL_B_W bits, one multiplier bit per cycle
  localparam int MUL_A_W   = 18;
  localparam int MUL_B_W   = 13;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // serial restoring divider: one quotient bit per cycle
  localparam int DIV_N_W   = 30;
  localparam int DIV_D_W   = 31;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURRENT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_MSTART,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// File: rtl/pmc_mul.sv
module pmc_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pmc_pkg::MUL_A_W-1:0] a,
  input  logic [pmc_pkg::MUL_B_W-1:0] b,
  output logic                        done,
  output logic [pmc_pkg::MUL_P_W-1:0] p
);
  import pmc_pkg::*;

  localparam logic [MUL_CNT_W-1:0] LAST = MUL_CNT_W'(MUL_B_W - 1);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [MUL_A_W-1:0]   mcand;
  logic [MUL_B_W-1:0]   mplier;
  logic [MUL_P_W-1:0]   acc;
  logic [MUL_A_W:0]     sum;

  // add the multiplicand into the upper part, then shift right one bit
  assign sum = {1'b0, acc[MUL_P_W-1:MUL_B_W]} + (mplier[0] ? {1'b0, mcand} : '0);
  assign p   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= a;
      mplier <= b;
      acc    <= '0;
    end else if (busy) begin
      acc    <= {sum, acc[MUL_B_W-1:1]};
      mplier <= mplier >> 1;
    end
  end

endmodule

// File: rtl/pmc_div.sv
module pmc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pmc_pkg::DIV_N_W-1:0] dividend,
  input  logic [pmc_pkg::DIV_D_W-1:0] divisor,
  output logic                        done,
  output logic [pmc_pkg::DIV_N_W-1:0] quotient
);
  import pmc_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DIV_N_W - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   dvsr;
  logic [DIV_N_W-1:0]   quo;
  logic [DIV_D_W+1:0]   trial;

  // remainder stays below the divisor, so one extra bit plus a sign bit suffice
  assign trial    = {1'b0, rem, quo[DIV_N_W-1]} - {2'b00, dvsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      if (!trial[DIV_D_W+1]) begin
        rem <= trial[DIV_D_W-1:0];
      end else begin
        rem <= {rem[DIV_D_W-2:0], quo[DIV_N_W-1]};
      end
      quo <= {quo[DIV_N_W-2:0], ~trial[DIV_D_W+1]};
    end
  end

endmodule

// File: rtl/motor_position_p_controller.sv
// Proportional position controller for one encoder axis. Each input transaction carries an
// encoder angle (8192 counts a turn), an optional microsecond timestamp, a multi-turn target,
// a current limit and a hold/run flag; each one yields exactly one output transaction with the
// drive current, the unwrapped position and a velocity in 1/32 rpm with its valid flag.
// Items are handled one at a time. Without a velocity an item goes from acceptance through
// the unwrap and fold step, the multiplier start, the bit-serial multiplication over the 13
// multiplier bits with its done flag, the output register load and the return to idle. A valid
// velocity adds the bit-serial divider over the 30 quotient bits, with its done flag, before
// the load. The finished result sits in an output register, so the next item is accepted
// while it waits to be taken; only a result still held there stalls the finishing step, for
// as long as it is not taken. Configuration writes (index 0 run gain Q8.8, 1 hold gain Q8.8,
// 2 max current; other indexes ignored) are always ready; the user must keep them to idle
// periods, which the block itself does not enforce. Reset values: run gain 8.0, hold gain
// 2.0, max current 12000, tracking state cleared; the first item seeds the previous angles.
module motor_position_p_controller (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // enc_angle[12:0], stamp_us[44:13], target_pos[73:45], item_limit[88:74], zero pad
  input  logic [95:0]                    s_tdata,
  // stamp_valid[0], hold_mode[1]
  input  logic [1:0]                     s_tuser,
  // output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // drive_current[15:0], position[44:16], velocity[75:45], zero pad
  output logic [79:0]                    m_tdata,
  // velocity_valid[0]
  output logic [0:0]                     m_tuser,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pmc_pkg::*;

  // fold a difference into [-half turn, +half turn]; exactly +-half is kept
  function automatic logic [ERR_W-1:0] fold_turn(input logic [29:0] d);
    logic [ANGLE_W-1:0] r;
    r = d[ANGLE_W-1:0];
    if (r == ANGLE_W'(HALF_TURN)) begin
      fold_turn = d[29] ? ERR_W'(-HALF_TURN) : ERR_W'(HALF_TURN);
    end else begin
      fold_turn = {r[ANGLE_W-1], r};
    end
  endfunction

  state_t state, state_next;

  // configuration registers
  logic [GAIN_W-1:0] run_gain;
  logic [GAIN_W-1:0] hold_gain;
  logic [LIM_W-1:0]  max_current;

  // latched input item
  logic [ANGLE_W-1:0] enc_angle;
  logic               stamp_valid;
  logic [STAMP_W-1:0] stamp_us;
  logic [POS_W-1:0]   target_pos;
  logic [LIM_W-1:0]   item_limit;
  logic               hold_mode;

  // tracking state
  logic               seeded;
  logic [ANGLE_W-1:0] prev_angle;
  logic [ANGLE_W-1:0] vel_base_angle;
  logic [STAMP_W-1:0] last_stamp;
  logic               stamp_seen;
  logic [TURN_W-1:0]  turn_count;

  // per-item intermediate results
  logic [ERR_W-1:0]   err;
  logic [ERR_W-1:0]   da;
  logic [DIV_D_W-1:0] dt;
  logic               vel_ok;
  logic [POS_W-1:0]   position;
  logic [LIM_W-1:0]   lim;
  logic [GAIN_W-1:0]  gain;

  // unwrap and fold logic
  logic [ANGLE_W-1:0]      la;
  logic [ANGLE_W-1:0]      vb;
  logic signed [ERR_W-1:0] step;
  logic [TURN_W-1:0]       turn_next;
  logic [POS_W-1:0]        pos_run;
  logic [POS_W-1:0]        pos_hold;
  logic [29:0]             d_err;
  logic [ERR_W-1:0]        d_ang;
  logic [STAMP_W-1:0]      dt_full;
  logic                    vel_ok_next;
  logic [LIM_W-1:0]        lim_next;

  // serial units
  logic                 mul_start;
  logic                 div_start;
  logic                 cur_done;
  logic                 vel_done;
  logic                 div_done;
  logic [MUL_P_W-1:0]   cur_prod;
  logic [MUL_P_W-1:0]   vel_prod;
  logic [DIV_N_W-1:0]   vel_quo;
  logic [ERR_W-1:0]     err_abs;
  logic [ERR_W-1:0]     da_abs;

  // result shaping
  logic [LIM_W-1:0] mag_cl;
  logic [CUR_W-1:0] drive_current;
  logic [VEL_W-1:0] velocity;
  logic             out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_gain    <= GAIN_W'(2048);
      hold_gain   <= GAIN_W'(512);
      max_current <= LIM_W'(12000);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RUN_GAIN:    run_gain    <= cfg_data;
        CFG_HOLD_GAIN:   hold_gain   <= cfg_data;
        CFG_MAX_CURRENT: max_current <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // input transaction latch
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      enc_angle   <= s_tdata[12:0];
      stamp_us    <= s_tdata[44:13];
      target_pos  <= s_tdata[73:45];
      item_limit  <= s_tdata[88:74];
      stamp_valid <= s_tuser[0];
      hold_mode   <= s_tuser[1];
    end
  end

  // unwrap, fold and qualify the velocity during the calculation state
  always_comb begin
    // the first item seeds the previous angles
    la        = seeded ? prev_angle : enc_angle;
    vb        = seeded ? vel_base_angle : enc_angle;
    step      = $signed({1'b0, enc_angle}) - $signed({1'b0, la});
    turn_next = turn_count;
    if (step > $signed(ERR_W'(HALF_TURN))) begin
      turn_next = turn_count - 1'b1;
    end else if (step < $signed(ERR_W'(-HALF_TURN))) begin
      turn_next = turn_count + 1'b1;
    end
    pos_run  = {turn_next[TURN_W-1], turn_next, enc_angle};
    pos_hold = {turn_count[TURN_W-1], turn_count, la};
    if (hold_mode) begin
      d_err = {target_pos[POS_W-1], target_pos} - {17'b0, enc_angle};
    end else begin
      d_err = {target_pos[POS_W-1], target_pos} - {pos_run[POS_W-1], pos_run};
    end
    d_ang       = {1'b0, enc_angle} - {1'b0, vb};
    dt_full     = stamp_us - last_stamp;
    // signed stamp delta must be positive
    vel_ok_next = !hold_mode && stamp_valid && stamp_seen && !dt_full[STAMP_W-1] &&
                  (dt_full != '0);
    lim_next    = (item_limit < max_current) ? item_limit : max_current;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded         <= 1'b0;
      prev_angle     <= '0;
      vel_base_angle <= '0;
      last_stamp     <= '0;
      stamp_seen     <= 1'b0;
      turn_count     <= '0;
    end else if (state == S_CALC) begin
      seeded <= 1'b1;
      // the first item seeds both angles in either mode
      if (!seeded || !hold_mode) begin
        prev_angle <= enc_angle;
      end
      if (!seeded || (!hold_mode && stamp_valid)) begin
        vel_base_angle <= enc_angle;
      end
      if (!hold_mode) begin
        turn_count <= turn_next;
        if (stamp_valid) begin
          last_stamp <= stamp_us;
          stamp_seen <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CALC) begin
      err      <= fold_turn(d_err);
      da       <= fold_turn({{16{d_ang[ERR_W-1]}}, d_ang});
      dt       <= dt_full[DIV_D_W-1:0];
      vel_ok   <= vel_ok_next;
      position <= hold_mode ? pos_hold : pos_run;
      lim      <= lim_next;
      gain     <= hold_mode ? hold_gain : run_gain;
    end
  end

  // magnitudes go through the serial units, signs are put back at the end
  assign err_abs = err[ERR_W-1] ? ERR_W'(-err) : err;
  assign da_abs  = da[ERR_W-1] ? ERR_W'(-da) : da;

  pmc_mul u_cur_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     ({2'b00, gain}),
    .b     (err_abs[MUL_B_W-1:0]),
    .done  (cur_done),
    .p     (cur_prod)
  );

  pmc_mul u_vel_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (MUL_A_W'(VEL_SCALE)),
    .b     (da_abs[MUL_B_W-1:0]),
    .done  (vel_done),
    .p     (vel_prod)
  );

  pmc_div u_vel_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (vel_prod[DIV_N_W-1:0]),
    .divisor  (dt),
    .done     (div_done),
    .quotient (vel_quo)
  );

  // Q8.8 product scaled down on its magnitude truncates toward zero, then clamp
  always_comb begin
    if (cur_prod[MUL_P_W-1:8] > {8'b0, lim}) begin
      mag_cl = lim;
    end else begin
      mag_cl = cur_prod[LIM_W+7:8];
    end
    drive_current = err[ERR_W-1] ? CUR_W'(-{1'b0, mag_cl}) : {1'b0, mag_cl};
    if (!vel_ok) begin
      velocity = '0;
    end else if (da[ERR_W-1]) begin
      velocity = VEL_W'(-{1'b0, vel_quo});
    end else begin
      velocity = {1'b0, vel_quo};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        state_next = S_MSTART;
      end
      S_MSTART: begin
        mul_start  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (cur_done) begin
          if (vel_ok) begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'b0, velocity, position, drive_current};
      m_tuser <= vel_ok;
    end
  end

`ifndef SYNTH
  // a result only appears after the finishing step
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("output valid rose outside the finishing step");

  // both multipliers run in lockstep
  a_mul_lockstep: assert property (@(posedge clk) disable iff (rst)
    cur_done == vel_done)
    else $error("multiplier done pulses out of step");

  // an invalid velocity is reported as zero
  a_vel_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[75:45] == '0))
    else $error("nonzero velocity without velocity_valid");
`endif

endmodule
